// ----- rtl/btpc_pkg.sv -----
// Shared types and constants for the barometer compensation block.
package btpc_pkg;
	localparam int unsigned WORD_W = 32;
	localparam int unsigned ADDR_W = 3;

	localparam logic [ADDR_W-1:0] REG_OSS    = 3'd0;
	localparam logic [ADDR_W-1:0] REG_AC1AC2 = 3'd1;
	localparam logic [ADDR_W-1:0] REG_AC3AC4 = 3'd2;
	localparam logic [ADDR_W-1:0] REG_AC5AC6 = 3'd3;
	localparam logic [ADDR_W-1:0] REG_B1B2   = 3'd4;
	localparam logic [ADDR_W-1:0] REG_MCMD   = 3'd5;
	localparam logic [ADDR_W-1:0] REG_WEIGHT = 3'd6;

	localparam logic [16:0] WEIGHT_RESET = 17'd6554;
	localparam logic [16:0] WEIGHT_ONE   = 17'd65536;

	localparam logic [31:0] C_4000  = 32'd4000;
	localparam logic [31:0] C_3038  = 32'd3038;
	localparam logic [31:0] C_M7357 = 32'hFFFF_E343;
	localparam logic [31:0] C_3791  = 32'd3791;
	localparam logic [31:0] C_50000 = 32'd50000;
	localparam logic [31:0] C_32768 = 32'd32768;

	typedef struct packed {
		logic [31:0] t;
		logic [31:0] p;
		logic        fault;
	} result_t;

	// divider handshake between the sequencer and the shared divider
	typedef struct packed {
		logic        start;
		logic        signed_op;
		logic [31:0] num;
		logic [31:0] den;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quo;
	} div_rsp_t;
endpackage

// ----- rtl/btpc_if.sv -----
// Valid/ready channel interfaces for items, results and register writes.
interface btpc_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] raw_temperature;
	logic [23:0] raw_pressure;
	modport source (output valid, raw_temperature, raw_pressure, input ready);
	modport sink (input valid, raw_temperature, raw_pressure, output ready);
endinterface

interface btpc_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] temperature_tenths;
	logic [31:0] pressure_pa;
	logic        divide_fault;
	modport source (output valid, temperature_tenths, pressure_pa, divide_fault,
		input ready);
	modport sink (input valid, temperature_tenths, pressure_pa, divide_fault,
		output ready);
endinterface

interface btpc_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/btpc_div.sv -----
// Shared restoring divider, one quotient bit per cycle, C-style truncation.
module btpc_div (
	input  logic               clk,
	input  logic               arst_n,
	input  btpc_pkg::div_req_t req,
	output btpc_pkg::div_rsp_t rsp
);
	logic        busy_q;
	logic [5:0]  cnt_q;
	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] dvs_q;
	logic        neg_q;
	logic [31:0] num_abs;
	logic [31:0] den_abs;
	logic [32:0] trial;
	logic [32:0] shifted;

	always_comb begin
		num_abs = (req.signed_op && req.num[31]) ? (32'd0 - req.num) : req.num;
		den_abs = (req.signed_op && req.den[31]) ? (32'd0 - req.den) : req.den;
		shifted = {rem_q, quo_q[31]};
		trial   = shifted - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			rsp    <= '0;
		end else begin
			rsp.done <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
				rem_q  <= '0;
				quo_q  <= num_abs;
				dvs_q  <= den_abs;
				neg_q  <= req.signed_op && (req.num[31] ^ req.den[31]);
			end else if (busy_q) begin
				if (!trial[32]) begin
					rem_q <= trial[31:0];
					quo_q <= {quo_q[30:0], 1'b1};
				end else begin
					rem_q <= shifted[31:0];
					quo_q <= {quo_q[30:0], 1'b0};
				end
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q   <= 1'b0;
					rsp.done <= 1'b1;
					rsp.quo  <= neg_q ? (32'd0 - {quo_q[30:0], ~trial[32]})
						: {quo_q[30:0], ~trial[32]};
				end
			end
		end
	end
endmodule

// ----- rtl/btpc_alu.sv -----
// Shared 32x32 multiplier with arithmetic or logical shift, registered result.
module btpc_alu (
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] b,
	input  logic [4:0]  sh,
	input  logic        lsr,
	output logic [31:0] y_q
);
	logic [31:0] prod;

	always_comb begin
		prod = a * b;
	end

	always_ff @(posedge clk) begin
		y_q <= lsr ? (prod >> sh) : 32'($signed(prod) >>> sh);
	end
endmodule

// ----- rtl/baro_temp_pressure_compensation.sv -----
// Top level: barometer compensation sequencer, registers and low-pass filter.
//
//  channel  dir  payload
//  in       in   raw_temperature[15:0], raw_pressure[23:0]
//  out      out  temperature_tenths[31:0], pressure_pa[31:0], divide_fault
//  cfg      in   index[2:0], data[31:0]
//
// A result is produced after two passes of the shared divider plus the steps
// of the sequencer and the shared multiply/shift unit. A zero divisor skips
// its divider pass. in.ready is high whenever the sequencer is idle, so a new
// request is taken only after the last one has left the sequencer; the output
// register holds one result until taken, and the sequencer stalls in its last
// step while that register is still full.
// arst_n clears control, registers and filter state. cfg is always ready.
module baro_temp_pressure_compensation (
	input  logic clk,
	input  logic arst_n,
	btpc_in_if.sink    in,
	btpc_out_if.source out,
	btpc_cfg_if.sink   cfg
);
	localparam logic [5:0] S_IDLE = 6'd0;
	localparam logic [5:0] S_X1   = 6'd1;
	localparam logic [5:0] S_DIVT = 6'd2;
	localparam logic [5:0] S_WT   = 6'd3;
	localparam logic [5:0] S_B5   = 6'd4;
	localparam logic [5:0] S_SQ   = 6'd5;
	localparam logic [5:0] S_P1   = 6'd6;
	localparam logic [5:0] S_P2   = 6'd7;
	localparam logic [5:0] S_P3   = 6'd8;
	localparam logic [5:0] S_P4   = 6'd9;
	localparam logic [5:0] S_P5   = 6'd10;
	localparam logic [5:0] S_B3   = 6'd11;
	localparam logic [5:0] S_B4   = 6'd12;
	localparam logic [5:0] S_B7   = 6'd13;
	localparam logic [5:0] S_DIVP = 6'd14;
	localparam logic [5:0] S_WP   = 6'd15;
	localparam logic [5:0] S_C1   = 6'd16;
	localparam logic [5:0] S_C2   = 6'd17;
	localparam logic [5:0] S_C3   = 6'd18;
	localparam logic [5:0] S_C4   = 6'd19;
	localparam logic [5:0] S_F1   = 6'd20;
	localparam logic [5:0] S_F2   = 6'd21;
	localparam logic [5:0] S_F3   = 6'd22;
	localparam logic [5:0] S_OUT  = 6'd23;

	logic [1:0]  oss_q;
	logic [31:0] r1_q, r2_q, r3_q, r4_q, r5_q;
	logic [16:0] w_q;
	logic [31:0] last_q;
	logic [5:0]  st_q;
	logic [15:0] ut_q;
	logic [31:0] up_q;
	logic [31:0] x1_q, b5_q, b6_q, sq_q, x3_q, b3_q, b4_q, b7_q, p_q, t_q;
	logic [63:0] acc_q;
	logic        fault_q;
	logic        ovld_q;
	btpc_pkg::result_t res_q;

	logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
	logic [31:0] ma, mb, my;
	logic [4:0]  msh;
	logic        mlsr;
	btpc_pkg::div_req_t dreq;
	btpc_pkg::div_rsp_t drsp;
	logic [16:0] wsat;
	logic [63:0] fprod;
	logic [63:0] facc;
	logic [31:0] b7s;

	assign ac1 = 32'($signed(r1_q[31:16]));
	assign ac2 = 32'($signed(r1_q[15:0]));
	assign ac3 = 32'($signed(r2_q[31:16]));
	assign ac4 = {16'd0, r2_q[15:0]};
	assign ac5 = {16'd0, r3_q[31:16]};
	assign ac6 = {16'd0, r3_q[15:0]};
	assign b1  = 32'($signed(r4_q[31:16]));
	assign b2  = 32'($signed(r4_q[15:0]));
	assign mc  = 32'($signed(r5_q[31:16]));
	assign md  = 32'($signed(r5_q[15:0]));
	assign wsat = (w_q > btpc_pkg::WEIGHT_ONE) ? btpc_pkg::WEIGHT_ONE : w_q;

	assign cfg.ready = 1'b1;
	assign in.ready  = (st_q == S_IDLE);
	assign out.valid = ovld_q;
	assign out.temperature_tenths = res_q.t;
	assign out.pressure_pa        = res_q.p;
	assign out.divide_fault       = res_q.fault;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oss_q <= '0;
			r1_q <= '0; r2_q <= '0; r3_q <= '0; r4_q <= '0; r5_q <= '0;
			w_q <= btpc_pkg::WEIGHT_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				btpc_pkg::REG_OSS:    oss_q <= cfg.data[1:0];
				btpc_pkg::REG_AC1AC2: r1_q <= cfg.data;
				btpc_pkg::REG_AC3AC4: r2_q <= cfg.data;
				btpc_pkg::REG_AC5AC6: r3_q <= cfg.data;
				btpc_pkg::REG_B1B2:   r4_q <= cfg.data;
				btpc_pkg::REG_MCMD:   r5_q <= cfg.data;
				btpc_pkg::REG_WEIGHT: w_q <= cfg.data[16:0];
				default: ;
			endcase
		end
	end

	// multiplier operands per step; result lands in my in the next cycle
	always_comb begin
		ma = '0; mb = '0; msh = '0; mlsr = 1'b0;
		case (st_q)
			S_X1: begin ma = {16'd0, ut_q} - ac6; mb = ac5; msh = 5'd15; end
			S_SQ: begin ma = b6_q; mb = b6_q; msh = 5'd12; end
			S_P1: begin ma = b2; mb = my; msh = 5'd11; end
			S_P2: begin ma = ac2; mb = b6_q; msh = 5'd11; end
			S_P3: begin ma = ac3; mb = b6_q; msh = 5'd13; end
			S_P4: begin ma = b1; mb = sq_q; msh = 5'd16; end
			S_B4: begin ma = ac4; mb = x3_q + btpc_pkg::C_32768; msh = 5'd15;
				mlsr = 1'b1; end
			S_B7: begin ma = up_q - b3_q; mb = btpc_pkg::C_50000 >> oss_q; end
			S_C1: begin ma = 32'($signed(p_q) >>> 8); mb = ma; end
			S_C2: begin ma = my; mb = btpc_pkg::C_3038; msh = 5'd16; end
			S_C3: begin ma = btpc_pkg::C_M7357; mb = p_q; msh = 5'd16; end
			default: ;
		endcase
	end

	btpc_alu u_alu (.clk(clk), .a(ma), .b(mb), .sh(msh), .lsr(mlsr), .y_q(my));
	btpc_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	// the temperature divisor and the pressure dividend come straight from the multiplier output in the start step
	assign b7s = my[31] ? my : {my[30:0], 1'b0};
	always_comb begin
		dreq = '0;
		if (st_q == S_DIVT && (my + md) != 32'd0) begin
			dreq.start = 1'b1; dreq.signed_op = 1'b1;
			dreq.num = mc << 11; dreq.den = my + md;
		end else if (st_q == S_DIVP && b4_q != 32'd0) begin
			dreq.start = 1'b1; dreq.num = b7s; dreq.den = b4_q;
		end
	end

	// filter: w*p and (65536-w)*last each fit a 17x32 product
	always_comb begin
		fprod = (st_q == S_F1)
			? 64'($signed({1'b0, wsat}) * $signed(p_q))
			: 64'($signed({1'b0, btpc_pkg::WEIGHT_ONE - wsat}) * $signed(last_q));
		facc = acc_q + (acc_q[63] ? 64'd65535 : 64'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			ovld_q <= 1'b0;
			last_q <= '0;
		end else begin
			if (ovld_q && out.ready && st_q != S_OUT) ovld_q <= 1'b0;
			case (st_q)
				S_IDLE: if (in.valid && in.ready) begin
					ut_q <= in.raw_temperature;
					up_q <= {8'd0, in.raw_pressure} >> (4'd8 - {2'd0, oss_q});
					fault_q <= 1'b0;
					st_q <= S_X1;
				end
				S_X1: st_q <= S_DIVT;
				S_DIVT: begin
					x1_q <= my;
					if ((my + md) == 32'd0) begin
						fault_q <= 1'b1; b5_q <= my; st_q <= S_B5;
					end else begin
						st_q <= S_WT;
					end
				end
				S_WT: if (drsp.done) begin
					b5_q <= x1_q + drsp.quo; st_q <= S_B5;
				end
				S_B5: begin
					t_q <= 32'($signed(b5_q + 32'd8) >>> 4);
					b6_q <= b5_q - btpc_pkg::C_4000;
					st_q <= S_SQ;
				end
				S_SQ: st_q <= S_P1;
				S_P1: begin sq_q <= my; st_q <= S_P2; end
				S_P2: begin x3_q <= my; st_q <= S_P3; end
				S_P3: begin x3_q <= x3_q + my; st_q <= S_P4; end
				S_P4: begin
					b3_q <= 32'($signed(((ac1 * 32'd4 + x3_q) << oss_q) + 32'd2) >>> 2);
					x1_q <= my; st_q <= S_P5;
				end
				S_P5: begin
					x3_q <= 32'($signed(x1_q + my + 32'd2) >>> 2); st_q <= S_B3;
				end
				S_B3: st_q <= S_B4;
				S_B4: st_q <= S_B7;
				S_B7: begin b4_q <= my; st_q <= S_DIVP; end
				S_DIVP: begin
					b7_q <= my;
					if (b4_q == 32'd0) begin
						fault_q <= 1'b1; p_q <= '0; st_q <= S_C1;
					end else begin
						st_q <= S_WP;
					end
				end
				S_WP: if (drsp.done) begin
					p_q <= b7_q[31] ? {drsp.quo[30:0], 1'b0} : drsp.quo;
					st_q <= S_C1;
				end
				S_C1: st_q <= S_C2;
				S_C2: begin x1_q <= my; st_q <= S_C3; end
				S_C3: begin x1_q <= my; st_q <= S_C4; end
				S_C4: begin
					p_q <= p_q + 32'($signed(x1_q + my + btpc_pkg::C_3791) >>> 4);
					st_q <= S_F1;
				end
				S_F1: begin acc_q <= fprod; st_q <= S_F2; end
				S_F2: begin acc_q <= acc_q + fprod; st_q <= S_F3; end
				S_F3: begin
					last_q <= facc[47:16];
					st_q <= S_OUT;
				end
				// wait here while the previous result is still held
				S_OUT: if (!ovld_q || out.ready) begin
					res_q.t <= t_q; res_q.p <= last_q; res_q.fault <= fault_q;
					ovld_q <= 1'b1; st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != S_IDLE) |-> !in.ready) else $error("accept while busy");
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(ovld_q && !out.ready) |=> (ovld_q && $stable(res_q)))
		else $error("result dropped");
	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		drsp.done |-> (st_q == S_WT || st_q == S_WP)) else $error("stray divide");
`endif
endmodule

// ----- dv/btpc_checker.sv -----
// Checker: watches the channels, predicts each compensated reading and compares.
`timescale 1ns / 1ps
module btpc_checker
	import btpc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	btpc_in_if         in_ch,
	btpc_out_if        out_ch,
	btpc_cfg_if        cfg_ch,
	output int         fails,
	output int         pending
);
	logic [1:0]         oss_reg;
	logic [31:0]        cal_ac12, cal_ac34, cal_ac56, cal_b12, cal_mcmd;
	logic [16:0]        weight_reg;
	logic signed [31:0] filt_state;
	result_t            expected_readings[$];

	assign pending = expected_readings.size();

	function automatic logic [31:0] asr(input logic [31:0] v, input int n);
		return 32'($signed(v) >>> n);
	endfunction

	function automatic logic [31:0] sx16(input logic [15:0] h);
		return {{16{h[15]}}, h};
	endfunction

	// integer compensation followed by the low-pass filter
	function automatic result_t compensate(input logic [15:0] ut_in, input logic [23:0] rp_in,
			input logic signed [31:0] prev, output logic signed [31:0] next_state);
		logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, ut, up;
		logic [31:0] x1, x2, x3, den, b5, b6, sq, b3, b4, b7, p, tmp;
		logic [16:0] w;
		longint q, acc;
		result_t r;
		ac1 = sx16(cal_ac12[31:16]); ac2 = sx16(cal_ac12[15:0]);
		ac3 = sx16(cal_ac34[31:16]); ac4 = {16'd0, cal_ac34[15:0]};
		ac5 = {16'd0, cal_ac56[31:16]}; ac6 = {16'd0, cal_ac56[15:0]};
		b1 = sx16(cal_b12[31:16]); b2 = sx16(cal_b12[15:0]);
		mc = sx16(cal_mcmd[31:16]); md = sx16(cal_mcmd[15:0]);
		ut = {16'd0, ut_in};
		up = {8'd0, rp_in};
		up = up >> (8 - oss_reg);
		r.fault = 1'b0;
		tmp = (ut - ac6) * ac5;
		x1 = asr(tmp, 15);
		den = x1 + md;
		if (den == 32'd0) begin
			x2 = 32'd0;
			r.fault = 1'b1;
		end else begin
			tmp = mc << 11;
			q = longint'($signed(tmp)) / longint'($signed(den));
			x2 = q[31:0];
		end
		b5 = x1 + x2;
		r.t = asr(b5 + 32'd8, 4);
		b6 = b5 - C_4000;
		tmp = b6 * b6;
		sq = asr(tmp, 12);
		tmp = b2 * sq;
		x1 = asr(tmp, 11);
		tmp = ac2 * b6;
		x2 = asr(tmp, 11);
		x3 = x1 + x2;
		tmp = ((ac1 * 32'd4 + x3) << oss_reg) + 32'd2;
		b3 = asr(tmp, 2);
		tmp = ac3 * b6;
		x1 = asr(tmp, 13);
		tmp = b1 * sq;
		x2 = asr(tmp, 16);
		x3 = asr(x1 + x2 + 32'd2, 2);
		tmp = ac4 * (x3 + C_32768);
		b4 = tmp >> 15;
		b7 = (up - b3) * (C_50000 >> oss_reg);
		if (b4 == 32'd0) begin
			p = 32'd0;
			r.fault = 1'b1;
		end else if (!b7[31]) begin
			p = (b7 * 32'd2) / b4;
		end else begin
			p = (b7 / b4) * 32'd2;
		end
		x1 = asr(p, 8);
		x1 = x1 * x1;
		tmp = x1 * C_3038;
		x1 = asr(tmp, 16);
		tmp = C_M7357 * p;
		x2 = asr(tmp, 16);
		p = p + asr(x1 + x2 + C_3791, 4);
		w = (weight_reg > WEIGHT_ONE) ? WEIGHT_ONE : weight_reg;
		acc = longint'(w) * longint'($signed(p)) + longint'(WEIGHT_ONE - w) * longint'(prev);
		acc = acc / 65536;
		next_state = acc[31:0];
		r.p = next_state;
		return r;
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
		fails++;
	endtask

	initial fails = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oss_reg <= 2'd0;
			cal_ac12 <= '0; cal_ac34 <= '0; cal_ac56 <= '0; cal_b12 <= '0; cal_mcmd <= '0;
			weight_reg <= WEIGHT_RESET;
			filt_state <= '0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				logic signed [31:0] nxt;
				expected_readings.push_back(compensate(in_ch.raw_temperature,
					in_ch.raw_pressure, filt_state, nxt));
				filt_state <= nxt;
			end
			if (out_ch.valid && out_ch.ready) begin
				if (expected_readings.size() == 0) begin
					report("unexpected reading", out_ch.pressure_pa, '0);
				end else begin
					result_t e;
					e = expected_readings.pop_front();
					if (out_ch.temperature_tenths !== e.t)
						report("temperature_tenths", out_ch.temperature_tenths, e.t);
					if (out_ch.pressure_pa !== e.p)
						report("pressure_pa", out_ch.pressure_pa, e.p);
					if (out_ch.divide_fault !== e.fault)
						report("divide_fault", {31'd0, out_ch.divide_fault}, {31'd0, e.fault});
				end
			end
			if (cfg_ch.valid && cfg_ch.ready) begin
				case (cfg_ch.index)
					REG_OSS: oss_reg <= cfg_ch.data[1:0];
					REG_AC1AC2: cal_ac12 <= cfg_ch.data;
					REG_AC3AC4: cal_ac34 <= cfg_ch.data;
					REG_AC5AC6: cal_ac56 <= cfg_ch.data;
					REG_B1B2: cal_b12 <= cfg_ch.data;
					REG_MCMD: cal_mcmd <= cfg_ch.data;
					REG_WEIGHT: weight_reg <= cfg_ch.data[16:0];
					default: ;
				endcase
			end
		end
	end
endmodule

// ----- dv/tb_baro_temp_pressure_compensation.sv -----
// Testbench top: drives readings and register writes, gives the verdict.
`timescale 1ns / 1ps
module tb_baro_temp_pressure_compensation;
	import btpc_pkg::*;

	localparam int STALL_LIMIT = 5000;
	localparam logic [2:0] REG_NONE = 3'd7;
	// typical factory calibration
	localparam logic [31:0] CAL_AC12 = {16'sd408, -16'sd72};
	localparam logic [31:0] CAL_AC34 = {-16'sd14383, 16'd32741};
	localparam logic [31:0] CAL_AC56 = {16'd32757, 16'd23153};
	localparam logic [31:0] CAL_B12  = {16'sd6190, 16'sd4};
	localparam logic [31:0] CAL_MCMD = {-16'sd8711, 16'sd2868};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   fails, pending, tx_idle = 0, rx_idle = 0, quiet = 0;
	bit   rx_hold = 1'b0, hold_go = 1'b0;

	btpc_in_if  in_ch ();
	btpc_out_if out_ch ();
	btpc_cfg_if cfg_ch ();

	baro_temp_pressure_compensation dut (.clk(clk), .arst_n(arst_n),
		.in(in_ch), .out(out_ch), .cfg(cfg_ch));

	btpc_checker chk (.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_ch(cfg_ch), .fails(fails), .pending(pending));

	always #1 clk = ~clk;

	initial begin
		in_ch.valid = 1'b0; in_ch.raw_temperature = '0; in_ch.raw_pressure = '0;
		cfg_ch.valid = 1'b0; cfg_ch.index = '0; cfg_ch.data = '0;
		out_ch.ready = 1'b0;
	end

	always @(posedge clk)
		out_ch.ready <= !rx_hold && ($urandom_range(99) >= rx_idle);

	// long receiver hold-off, timed here so the sender keeps offering
	initial begin
		wait (hold_go);
		rx_hold = 1'b1;
		repeat (600) @(posedge clk);
		rx_hold = 1'b0;
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic send_reading(input logic [15:0] ut, input logic [23:0] rp);
		if ($urandom_range(99) < tx_idle) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < tx_idle) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.raw_temperature <= ut;
		in_ch.raw_pressure <= rp;
		forever begin
			@(negedge clk);
			if (in_ch.ready) break;
			@(posedge clk);
		end
		@(posedge clk);
	endtask

	// let every request drain, then give the block time to go idle
	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		forever begin
			@(negedge clk);
			if (cfg_ch.ready) break;
			@(posedge clk);
		end
		@(posedge clk);
	endtask

	task automatic load_calibration(input logic [31:0] a12, a34, a56, b12, mcmd);
		write_reg(REG_AC1AC2, a12);
		write_reg(REG_AC3AC4, a34);
		write_reg(REG_AC5AC6, a56);
		write_reg(REG_B1B2, b12);
		write_reg(REG_MCMD, mcmd);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic set_reg(input logic [2:0] idx, input logic [31:0] value);
		write_reg(idx, value);
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic logic [15:0] jitter(input logic [15:0] v, input int span);
		return v + 16'($urandom_range(2 * span) - span);
	endfunction

	initial begin
		logic [1:0] oss;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// all-zero calibration: both divisors are zero
		send_reading(16'd0, 24'd0);
		send_reading(16'hFFFF, 24'hFFFFFF);
		drain();
		load_calibration(CAL_AC12, CAL_AC34, CAL_AC56, CAL_B12, CAL_MCMD);
		set_reg(REG_WEIGHT, 32'd65536);
		send_reading(16'd27898, 24'd23843 << 8);
		send_reading(16'd0, 24'd0);
		send_reading(16'hFFFF, 24'hFFFFFF);
		send_reading(16'h5555, 24'hAAAAAA);
		send_reading(16'hAAAA, 24'h555555);
		drain();
		// temperature divisor zero only
		set_reg(REG_MCMD, {CAL_MCMD[31:16], 16'd0});
		set_reg(REG_AC5AC6, {16'd0, CAL_AC56[15:0]});
		send_reading(16'd27898, 24'd23843 << 8);
		drain();
		load_calibration(CAL_AC12, CAL_AC34, CAL_AC56, CAL_B12, CAL_MCMD);
		set_reg(REG_WEIGHT, 32'd0);
		send_reading(16'd27898, 24'd23843 << 8);
		drain();
		set_reg(REG_WEIGHT, 32'h1FFFF);  // above one, saturates
		set_reg(REG_NONE, 32'hDEADBEEF); // ignored index
		set_reg(REG_OSS, 32'd3);
		send_reading(16'd27898, 24'd23843 << 5);
		send_reading(16'hFFFF, 24'hFFFFFF);
		drain();
		set_reg(REG_WEIGHT, WEIGHT_RESET);
		set_reg(REG_OSS, 32'd1);
		send_reading(16'd27898, 24'd23843 << 7);
		send_reading(16'd30000, 24'd23843 << 7);
		drain();
		set_reg(REG_OSS, 32'd2);
		send_reading(16'd27898, 24'd23843 << 6);
		send_reading(16'd20000, 24'd40000 << 6);
		drain();

		for (int phase = 0; phase < 10; phase++) begin
			bit real_cal;
			tx_idle = (phase < 4) ? 30 : (phase < 7) ? 54 : 0;
			rx_idle = (phase < 4) ? 54 : (phase < 7) ? 30 : 0;
			real_cal = $urandom_range(3) != 0;
			oss = 2'($urandom_range(3));
			if (real_cal)
				load_calibration({jitter(CAL_AC12[31:16], 50), jitter(CAL_AC12[15:0], 50)},
					{jitter(CAL_AC34[31:16], 200), jitter(CAL_AC34[15:0], 300)},
					{jitter(CAL_AC56[31:16], 300), jitter(CAL_AC56[15:0], 300)},
					{jitter(CAL_B12[31:16], 100), jitter(CAL_B12[15:0], 3)},
					{jitter(CAL_MCMD[31:16], 100), jitter(CAL_MCMD[15:0], 100)});
			else
				load_calibration($urandom, $urandom, $urandom, $urandom, $urandom);
			set_reg(REG_OSS, {30'd0, oss});
			case (phase % 4)
				0: set_reg(REG_WEIGHT, 32'($urandom_range(65536)));
				1: set_reg(REG_WEIGHT, 32'd65536);
				2: set_reg(REG_WEIGHT, 32'd0);
				default: set_reg(REG_WEIGHT, 32'($urandom_range(131071)));
			endcase
			for (int n = 0; n < 85; n++) begin
				if (phase == 2 && n == 5) hold_go = 1'b1;
				if (phase == 5 && n == 40) begin
					in_ch.valid <= 1'b0;
					@(posedge clk);
					while (pending != 0) @(posedge clk);
				end
				if (real_cal && $urandom_range(4) != 0)
					send_reading(16'($urandom_range(35000, 20000)),
						24'($urandom_range(45000, 15000)) << (8 - oss));
				else
					send_reading(16'($urandom), 24'($urandom));
			end
			drain();
		end

		if (fails == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
